@@ rtl/core/dsmc_pkg.sv @@
// Package of shared types, constants and modular arithmetic helpers for the digit-sum counter.
package dsmc_pkg;

  localparam int unsigned DataW = 30;
  localparam logic [DataW-1:0] CountPrime = 30'd1000000007;
  localparam logic [3:0] DigitBase = 4'd10;
  localparam logic [3:0] DigitMax = 4'd9;

  typedef logic [DataW-1:0] count_t;

  // Control of one sliding-window accumulator.
  typedef struct packed {
    logic clr;
    logic en;
    logic sub_en;
  } win_ctrl_t;

  // Both operands are below the prime, so one conditional subtract suffices.
  function automatic count_t add_mod(count_t a, count_t b);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, CountPrime}) begin
      s = s - {1'b0, CountPrime};
    end
    return s[DataW-1:0];
  endfunction

  function automatic count_t sub_mod(count_t a, count_t b);
    logic [DataW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[DataW]) begin
      d = d + {1'b0, CountPrime};
    end
    return d[DataW-1:0];
  endfunction

endpackage

@@ rtl/core/dsmc_if.sv @@
// Handshake interfaces for the digit input channel and the count result channel.
interface dsmc_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic       last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink (input valid, input digit, input last_digit, output ready);
endinterface

interface dsmc_out_if;
  logic              valid;
  logic              ready;
  dsmc_pkg::count_t  count;

  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

@@ rtl/core/dsmc_table_mem.sv @@
// Count table memory with one write port and two registered read ports.
module dsmc_table_mem #(
  parameter int unsigned AddrW = 8
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  dsmc_pkg::count_t       wdata_i,
  input  logic [AddrW-1:0]       raddr_a_i,
  input  logic [AddrW-1:0]       raddr_b_i,
  output dsmc_pkg::count_t       rdata_a_o,
  output dsmc_pkg::count_t       rdata_b_o
);
  import dsmc_pkg::*;

  count_t mem_q [2**AddrW];
  count_t rdata_a_q;
  count_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/core/dsmc_window_acc.sv @@
// Sliding-window modular accumulator: adds the entering entry and drops the leaving one.
module dsmc_window_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dsmc_pkg::win_ctrl_t  ctrl_i,
  input  dsmc_pkg::count_t     add_i,
  input  dsmc_pkg::count_t     sub_i,
  output dsmc_pkg::count_t     sum_o
);
  import dsmc_pkg::*;

  count_t sum_q;
  count_t sum_d;
  count_t drop;

  always_comb begin
    drop  = ctrl_i.sub_en ? sub_i : '0;
    sum_d = sub_mod(add_mod(sum_q, add_i), drop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clr) begin
      sum_q <= '0;
    end else if (ctrl_i.en) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/core/digit_sum_mod_count.sv @@
// Top level of the digit-sum divisibility counter: sequencer, table memories and result register.
// A digit item keeps the block busy for one sweep over the table memories, m being the active
// modulus (sum_modulus clamped to 1..MAX_MODULUS). A new item is taken only when the block is
// idle again, after the sweep has drained and a last item has handed its count to the result
// register. The sweep has m + 9 read steps (one residue per cycle plus nine warm-up steps of the
// ten-digit window) through a three-stage read, accumulate and write-back pipeline.
// Reset sets sum_modulus to 1 and marks the tables as being in the start state; no clearing pass.
module digit_sum_mod_count #(
  parameter int unsigned MAX_MODULUS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  dsmc_in_if.sink             in_i,
  dsmc_out_if.source          out_o
);
  import dsmc_pkg::*;

  localparam int unsigned IdxW  = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
  localparam int unsigned ModW  = $clog2(MAX_MODULUS + 1);
  localparam int unsigned StepW = $clog2(MAX_MODULUS + 9);
  localparam int unsigned AddrW = IdxW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Control that travels with the reads of one sweep step.
  typedef struct packed {
    logic            vld;
    logic            use_b;
    logic            use_e;
    logic            wr;
    logic [IdxW-1:0] widx;
    logic            add_zero;
    logic            subb_zero;
    logic            sube_zero;
    logic            add_one;
    logic            sube_one;
  } stage1_t;

  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] widx;
    count_t          eq_next;
  } stage2_t;

  logic [1:0]      state_q;
  logic [6:0]      sum_modulus_q;
  logic [3:0]      digit_q;
  logic            last_q;
  logic [3:0]      span_q;
  logic [ModW-1:0] m_q;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0] add_idx_q;
  logic [IdxW-1:0] subb_idx_q;
  logic [IdxW-1:0] sube_idx_q;
  logic            bank_q;
  logic [ModW-1:0] extent_q;
  logic            fresh_q;
  stage1_t         s1_q;
  stage2_t         s2_q;
  count_t          v0_q;
  logic            out_vld_q;
  count_t          count_q;

  // The current tables sit in bank bank_q; a sweep reads them and writes the other bank.
  // Entries at or above extent_q were never written for the current tables and read as
  // zero; while fresh_q is set the tables are in the start state whatever the memory holds.

  logic            in_accept;
  logic            issue;
  logic            use_b;
  logic            use_e;
  logic            wr_step;
  logic [StepW-1:0] last_step;
  logic [ModW-1:0] active_m;
  logic            out_free;
  logic            out_load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign issue      = (state_q == ST_RUN);
  assign out_free   = !out_vld_q || out_o.ready;
  // A last item hands its count to the result register as it leaves the finish state.
  assign out_load   = (state_q == ST_FINISH) && last_q && out_free;

  // Window bookkeeping: the below window always spans ten digits, the equal window spans the
  // digits under the bound digit (all ten when the digit exceeds nine).
  assign use_b     = step_q >= StepW'(DigitBase);
  assign use_e     = step_q >= StepW'(span_q);
  assign wr_step   = step_q >= StepW'(DigitMax);
  assign last_step = StepW'(m_q) + StepW'(DigitMax - 4'd1);

  always_comb begin
    if (sum_modulus_q == 7'd0) begin
      active_m = ModW'(1);
    end else if (32'(sum_modulus_q) > 32'(MAX_MODULUS)) begin
      active_m = ModW'(MAX_MODULUS);
    end else begin
      active_m = ModW'(sum_modulus_q);
    end
  end

  function automatic logic idx_zero(logic [IdxW-1:0] idx, logic fresh,
                                    logic [ModW-1:0] extent);
    return fresh || (ModW'(idx) >= extent);
  endfunction

  function automatic logic [IdxW-1:0] idx_next(logic [IdxW-1:0] idx, logic [ModW-1:0] m);
    return (ModW'(idx) == m - ModW'(1)) ? '0 : idx + IdxW'(1);
  endfunction

  // Table memories.
  count_t eq_rd_a, eq_rd_b, bl_rd_a, bl_rd_b;
  count_t bl_wdata;
  logic [AddrW-1:0] waddr;

  assign waddr = {~bank_q, s2_q.widx};

  dsmc_table_mem #(.AddrW(AddrW)) u_eq_mem (
    .clk_i     (clk_i),
    .we_i      (s2_q.vld),
    .waddr_i   (waddr),
    .wdata_i   (s2_q.eq_next),
    .raddr_a_i ({bank_q, add_idx_q}),
    .raddr_b_i ({bank_q, sube_idx_q}),
    .rdata_a_o (eq_rd_a),
    .rdata_b_o (eq_rd_b)
  );

  dsmc_table_mem #(.AddrW(AddrW)) u_below_mem (
    .clk_i     (clk_i),
    .we_i      (s2_q.vld),
    .waddr_i   (waddr),
    .wdata_i   (bl_wdata),
    .raddr_a_i ({bank_q, add_idx_q}),
    .raddr_b_i ({bank_q, subb_idx_q}),
    .rdata_a_o (bl_rd_a),
    .rdata_b_o (bl_rd_b)
  );

  // Read data after the start-state and extent masks.
  count_t eq_add, eq_sub, bl_add, bl_sub;

  always_comb begin
    eq_add = s1_q.add_one  ? count_t'(1) : (s1_q.add_zero  ? '0 : eq_rd_a);
    eq_sub = s1_q.sube_one ? count_t'(1) : (s1_q.sube_zero ? '0 : eq_rd_b);
    bl_add = s1_q.add_zero  ? '0 : bl_rd_a;
    bl_sub = s1_q.subb_zero ? '0 : bl_rd_b;
  end

  // Sliding sums: the below window over the below table, the partial window over the equal table.
  win_ctrl_t win_b_ctrl, win_e_ctrl;
  count_t    win_b_sum, win_e_sum;

  assign win_b_ctrl = '{clr: in_accept, en: s1_q.vld, sub_en: s1_q.use_b};
  assign win_e_ctrl = '{clr: in_accept, en: s1_q.vld, sub_en: s1_q.use_e};

  dsmc_window_acc u_win_below (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_b_ctrl),
    .add_i  (bl_add),
    .sub_i  (bl_sub),
    .sum_o  (win_b_sum)
  );

  dsmc_window_acc u_win_equal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_e_ctrl),
    .add_i  (eq_add),
    .sub_i  (eq_sub),
    .sum_o  (win_e_sum)
  );

  // A new below entry gets every prefix that moved below; a new equal entry is the one
  // equal prefix extended by the bound digit itself, which is the entry leaving the window.
  assign bl_wdata = add_mod(win_b_sum, win_e_sum);

  // Pipeline registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q.vld       <= issue;
      s1_q.use_b     <= use_b;
      s1_q.use_e     <= use_e;
      s1_q.wr        <= wr_step;
      s1_q.widx      <= add_idx_q;
      s1_q.add_zero  <= idx_zero(add_idx_q, fresh_q, extent_q);
      s1_q.subb_zero <= idx_zero(subb_idx_q, fresh_q, extent_q);
      s1_q.sube_zero <= idx_zero(sube_idx_q, fresh_q, extent_q);
      s1_q.add_one   <= fresh_q && (add_idx_q == '0);
      s1_q.sube_one  <= fresh_q && (sube_idx_q == '0);
      s2_q.vld       <= s1_q.vld && s1_q.wr;
      s2_q.widx      <= s1_q.widx;
      s2_q.eq_next   <= (digit_q <= DigitMax) ? eq_sub : '0;
    end
  end

  // Entry zero of the new tables is kept for the count of a last item.
  always_ff @(posedge clk_i) begin
    if (s2_q.vld && (s2_q.widx == '0)) begin
      v0_q <= add_mod(bl_wdata, s2_q.eq_next);
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sum_modulus_q <= 7'd1;
      m_q           <= ModW'(1);
      step_q        <= '0;
      add_idx_q     <= '0;
      subb_idx_q    <= '0;
      sube_idx_q    <= '0;
      bank_q        <= 1'b0;
      extent_q      <= ModW'(1);
      fresh_q       <= 1'b1;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sum_modulus_q <= cfg_wdata_i;
      end
      // A new count may replace one that is taken in the same cycle.
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            m_q        <= active_m;
            step_q     <= '0;
            add_idx_q  <= '0;
            subb_idx_q <= '0;
            sube_idx_q <= '0;
            state_q    <= ST_RUN;
          end
        end
        ST_RUN: begin
          step_q    <= step_q + StepW'(1);
          add_idx_q <= idx_next(add_idx_q, m_q);
          if (use_b) begin
            subb_idx_q <= idx_next(subb_idx_q, m_q);
          end
          if (use_e) begin
            sube_idx_q <= idx_next(sube_idx_q, m_q);
          end
          if (step_q == last_step) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_q.vld && !s2_q.vld) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // A last item waits here until the result register is free.
          if (!last_q || out_free) begin
            bank_q   <= ~bank_q;
            extent_q <= m_q;
            fresh_q  <= last_q;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Item payload and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      digit_q <= in_i.digit;
      last_q  <= in_i.last_digit;
      span_q  <= (in_i.digit > DigitMax) ? DigitBase : in_i.digit;
    end
    if (out_load) begin
      // Zero itself is counted by the start state and is taken off here.
      count_q <= add_mod(v0_q, CountPrime - count_t'(1));
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.count = count_q;

  // Write-back only touches residues of the active modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.vld |-> (ModW'(s2_q.widx) < m_q))
    else $error("write-back index outside the active modulus");

  // A shown count is a proper residue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_o.count < CountPrime))
    else $error("result count not reduced");

  // The pipeline is empty whenever a new item can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_q.vld && !s2_q.vld))
    else $error("sweep still in flight while idle");

  // The sliding sums stay reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_b_sum < CountPrime) && (win_e_sum < CountPrime))
    else $error("window sum not reduced");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the digit-sum divisibility counter, with its own digit-DP predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Table depth of the block and of the predictor.
  localparam int MaxMod = 128;
  // Least number of input items in the run; no new random phase starts once it is reached.
  localparam int ItemTarget = 1300;
  // In the final stretch of the run neither side idles.
  localparam int CalmTail = 150;
  // Length of the one long receiver hold-off, in cycles.
  localparam int LongHold = 1500;
  // Watchdog: the slowest correct run is far below this.
  localparam int CycleLimit = 4000000;
  localparam logic [31:0] Prime = 32'(dsmc_pkg::CountPrime);

  // One row of the directed table: either a digit item or a modulus write.
  typedef enum logic {
    ROW_ITEM,
    ROW_MODULUS
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [3:0]        digit;
    logic              is_last;
    logic              pinned;   // the count below is typed in, not predicted
    dsmc_pkg::count_t  want;
    logic [6:0]        modulus;
  } dir_row_t;

  // Per accepted item: whether its count is pinned by the directed table.
  typedef struct packed {
    logic              pinned;
    dsmc_pkg::count_t  want;
  } pin_t;

  localparam int NumRows = 26;
  // The directed part. Counts are typed in where they are obvious: with a
  // modulus of one every number counts, and no sum of two digits reaches 127.
  localparam dir_row_t DirRows [NumRows] = '{
    '{ROW_ITEM,    4'd9,  1'b1, 1'b1, 30'd9,   7'd0},    // largest digit, single digit
    '{ROW_ITEM,    4'd0,  1'b1, 1'b1, 30'd0,   7'd0},    // zero itself never counts
    '{ROW_ITEM,    4'd15, 1'b1, 1'b1, 30'd9,   7'd0},    // digit above nine: all below
    '{ROW_ITEM,    4'd1,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd0,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd0,  1'b1, 1'b1, 30'd100, 7'd0},    // K = 100
    '{ROW_MODULUS, 4'd0,  1'b0, 1'b0, 30'd0,   7'd0},    // zero modulus acts as one
    '{ROW_ITEM,    4'd5,  1'b1, 1'b1, 30'd5,   7'd0},
    '{ROW_MODULUS, 4'd0,  1'b0, 1'b0, 30'd0,   7'd127},  // largest register value
    '{ROW_ITEM,    4'd9,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd9,  1'b1, 1'b1, 30'd0,   7'd0},    // no sum up to 18 divides by 127
    '{ROW_MODULUS, 4'd0,  1'b0, 1'b0, 30'd0,   7'd10},
    '{ROW_ITEM,    4'd1,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd0,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd0,  1'b1, 1'b0, 30'd0,   7'd0},
    '{ROW_MODULUS, 4'd0,  1'b0, 1'b0, 30'd0,   7'd3},
    '{ROW_ITEM,    4'd12, 1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd3,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_MODULUS, 4'd0,  1'b0, 1'b0, 30'd0,   7'd7},    // modulus changes mid-number
    '{ROW_ITEM,    4'd4,  1'b1, 1'b0, 30'd0,   7'd0},
    '{ROW_MODULUS, 4'd0,  1'b0, 1'b0, 30'd0,   7'd2},
    '{ROW_ITEM,    4'd9,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd9,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd9,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd9,  1'b0, 1'b0, 30'd0,   7'd0},
    '{ROW_ITEM,    4'd9,  1'b1, 1'b0, 30'd0,   7'd0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  dsmc_in_if  digit_bus ();
  dsmc_out_if count_bus ();

  digit_sum_mod_count #(
    .MAX_MODULUS(MaxMod)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (digit_bus),
    .out_o      (count_bus)
  );

  // Predictor state: the modulus register and the two residue tables.
  // eq_tbl counts prefixes still equal to the bound, lt_tbl those already below.
  logic [6:0]  mod_setting;
  logic [31:0] eq_tbl [MaxMod];
  logic [31:0] lt_tbl [MaxMod];

  dsmc_pkg::count_t count_q [$];   // counts still owed by the block, oldest first
  pin_t             pin_q [$];     // one entry per item offered, in offer order

  int items_sent = 0;
  int quiet_cycles = 0;    // cycles since the last accepted digit item
  int mismatches = 0;
  bit calm = 1'b0;         // no idling on either side
  bit long_hold_pending = 1'b0;

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog. A hung handshake ends the run here.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] mod_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if (s >= Prime) begin
      s = s - Prime;
    end
    return s;
  endfunction

  // The block clamps the register to 1..MaxMod before using it.
  function automatic int eff_modulus();
    if (mod_setting == 7'd0) begin
      return 1;
    end
    if (int'(mod_setting) > MaxMod) begin
      return MaxMod;
    end
    return int'(mod_setting);
  endfunction

  // Start state of a number: only the empty prefix, equal to the bound, sum zero.
  task automatic clear_tables();
    for (int j = 0; j < MaxMod; j++) begin
      eq_tbl[j] = '0;
      lt_tbl[j] = '0;
    end
    eq_tbl[0] = 32'd1;
  endtask

  // One digit of the bound: every residue entry below the active modulus is
  // pushed through the ten placeable digits. Digits under the bound digit move
  // an equal prefix below the bound; the bound digit itself keeps it equal.
  // Entries at or above the modulus are not read and come out as zero.
  task automatic advance_digit(input logic [3:0] bound, input logic is_last,
                               output bit has_cnt, output dsmc_pkg::count_t cnt);
    logic [31:0] nx_eq [MaxMod];
    logic [31:0] nx_lt [MaxMod];
    logic [31:0] ev;
    logic [31:0] bv;
    logic [31:0] total;
    int m;
    int j;
    int x;
    int r;
    m = eff_modulus();
    for (j = 0; j < MaxMod; j++) begin
      nx_eq[j] = '0;
      nx_lt[j] = '0;
    end
    for (j = 0; j < m; j++) begin
      ev = eq_tbl[j] % Prime;
      bv = lt_tbl[j] % Prime;
      for (x = 0; x < int'(dsmc_pkg::DigitBase); x++) begin
        r = (j + x) % m;
        nx_lt[r] = mod_sum(nx_lt[r], bv);
        if (x < int'(bound)) begin
          nx_lt[r] = mod_sum(nx_lt[r], ev);
        end else if (x == int'(bound)) begin
          nx_eq[r] = mod_sum(nx_eq[r], ev);
        end
      end
    end
    for (j = 0; j < MaxMod; j++) begin
      eq_tbl[j] = nx_eq[j];
      lt_tbl[j] = nx_lt[j];
    end
    has_cnt = is_last;
    cnt = '0;
    if (is_last) begin
      // Residue zero of both tables, minus one for the number zero.
      total = mod_sum(mod_sum(eq_tbl[0], lt_tbl[0]), Prime - 32'd1);
      cnt = total[dsmc_pkg::DataW-1:0];
      clear_tables();
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Offers one digit item and returns at the edge where it is taken. Valid is
  // left high, so a following item without a gap goes out back to back.
  task automatic send_item(input logic [3:0] dg, input logic is_last,
                           input logic pinned, input dsmc_pkg::count_t want);
    int   gap;
    pin_t pn;
    calm = (items_sent >= ItemTarget - CalmTail);
    gap = (!calm && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
    if (gap > 0) begin
      digit_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pn.pinned = pinned;
    pn.want   = want;
    pin_q.insert(pin_q.size(), pn);
    digit_bus.valid      <= 1'b1;
    digit_bus.digit      <= dg;
    digit_bus.last_digit <= is_last;
    do @(posedge clk_i); while (!digit_bus.ready);
    items_sent++;
  endtask

  // Stops offering and waits until every owed count has come out. Always
  // advances at least one edge, so callers never stack two drives in one step.
  task automatic drain();
    digit_bus.valid <= 1'b0;
    do @(posedge clk_i); while (count_q.size() != 0);
  endtask

  // Writes the modulus with the block idle. A digit that is not last gives no
  // count, so after the drain the sweep of such a digit may still be running;
  // twice the block's busy time is left to pass first.
  task automatic set_modulus(input logic [6:0] value);
    int settle;
    settle = 2 * (eff_modulus() + 14) + 4;
    drain();
    while (quiet_cycles < settle) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Receiver. Stalls in random bursts, except in the calm tail, and once holds
  // off for a long stretch so that the block fills up and stalls its input.
  always begin
    @(posedge clk_i);
    if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      count_bus.ready <= 1'b0;
      repeat (LongHold) @(posedge clk_i);
      count_bus.ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      count_bus.ready <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
      count_bus.ready <= 1'b1;
    end else begin
      count_bus.ready <= 1'b1;
    end
  end

  // Monitor and scoreboard. Everything is sampled at the rising edge, before
  // the drivers' nonblocking updates land, so it sees what the block sees.
  always @(posedge clk_i) begin : scoreboard
    pin_t             pin;
    bit               has_cnt;
    dsmc_pkg::count_t cnt;
    dsmc_pkg::count_t want;
    if (rst_ni) begin
      if (count_bus.valid && count_bus.ready) begin
        if (count_q.size() == 0) begin
          note_mismatch($sformatf("count %0d with nothing pending", count_bus.count));
        end else begin
          want = count_q.pop_front();
          if (count_bus.count !== want) begin
            note_mismatch($sformatf("count %0d, expected %0d", count_bus.count, want));
          end
        end
      end
      if (cfg_we) begin
        mod_setting = cfg_wdata;
      end
      if (digit_bus.valid && digit_bus.ready) begin
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        advance_digit(digit_bus.digit, digit_bus.last_digit, has_cnt, cnt);
        if (has_cnt) begin
          count_q.insert(count_q.size(), pin.pinned ? pin.want : cnt);
        end
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    logic [3:0] dg;
    logic [6:0] mv;
    int         i;
    int         k;
    int         d;
    int         len;
    int         nums;
    int         pick;
    bit         broken;
    bit         hold_done;
    bit         pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    mod_setting = 7'd1;
    clear_tables();

    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    digit_bus.valid      <= 1'b0;
    digit_bus.digit      <= '0;
    digit_bus.last_digit <= 1'b0;
    count_bus.ready      <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset modulus of one.
    for (i = 0; i < NumRows; i++) begin
      row = DirRows[i];
      if (row.kind == ROW_MODULUS) begin
        set_modulus(row.modulus);
      end else begin
        send_item(row.digit, row.is_last, row.pinned, row.want);
      end
    end

    // Random part: phases of whole numbers under one modulus. Now and then the
    // last number of a phase is left open, so the next modulus write lands
    // mid-number. A few digits are out of range as noise.
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          mv = 7'd0;
        end
        1: begin
          mv = 7'd1;
        end
        2: begin
          mv = 7'd127;
        end
        3, 4, 5: begin
          mv = 7'($urandom_range(2, 12));
        end
        default: begin
          mv = 7'($urandom_range(0, 127));
        end
      endcase
      set_modulus(mv);
      nums   = $urandom_range(2, 8);
      broken = ($urandom_range(0, 4) == 0);
      for (k = 0; k < nums; k++) begin
        // Long bounds push the counts past the prime; short ones are cheap results.
        len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3))
                                          : int'($urandom_range(4, 24));
        for (d = 0; d < len; d++) begin
          dg = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
          send_item(dg, (d == len - 1) && !(broken && k == nums - 1), 1'b0, '0);
        end
        // Once in the run the sender stops until every count is back.
        if (!pause_done && items_sent >= 800) begin
          pause_done = 1'b1;
          drain();
        end
      end
      // Once in the run the receiver holds off while single-digit bounds keep
      // coming, each one owing a count, so the input side must back up.
      if (!hold_done && items_sent >= 400) begin
        hold_done = 1'b1;
        long_hold_pending = 1'b1;
        repeat (24) send_item(4'($urandom_range(0, 9)), 1'b1, 1'b0, '0);
      end
    end

    drain();
    repeat (2 * (eff_modulus() + 14) + 10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
